// ===== rtl/skin_pixel_centroid_defines.svh =====
// ----------------------------------------------------------------------------
// Skin pixel centroid assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SKIN_PIXEL_CENTROID_DEFINES_SVH
`define SKIN_PIXEL_CENTROID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// Skin pixel centroid package
// Widths, register indexes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 21;
  localparam int SUM_W   = 30;
  localparam int INDEX_W = 3;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam logic [INDEX_W-1:0] REG_LUMA_LOW  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LUMA_HIGH = 3'd1;
  localparam logic [INDEX_W-1:0] REG_CR_LOW    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_CR_HIGH   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_CB_LOW    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_CB_HIGH   = 3'd5;

  localparam logic [CHAN_W-1:0] RST_LUMA_LOW  = 8'd77;
  localparam logic [CHAN_W-1:0] RST_LUMA_HIGH = 8'd127;
  localparam logic [CHAN_W-1:0] RST_CR_LOW    = 8'd133;
  localparam logic [CHAN_W-1:0] RST_CR_HIGH   = 8'd173;
  localparam logic [CHAN_W-1:0] RST_CB_LOW    = 8'd0;
  localparam logic [CHAN_W-1:0] RST_CB_HIGH   = 8'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] luma_low;
    logic [CHAN_W-1:0] luma_high;
    logic [CHAN_W-1:0] cr_low;
    logic [CHAN_W-1:0] cr_high;
    logic [CHAN_W-1:0] cb_low;
    logic [CHAN_W-1:0] cb_high;
  } bounds_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scp_accum.sv =====
// ----------------------------------------------------------------------------
// Skin pixel classifier and accumulator
// Tests each pixel against the bounds and keeps the count and coordinate sums.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          update,
  input  logic [scp_pkg::CHAN_W-1:0]    luma,
  input  logic [scp_pkg::CHAN_W-1:0]    chroma_red,
  input  logic [scp_pkg::CHAN_W-1:0]    chroma_blue,
  input  logic [scp_pkg::COORD_W-1:0]   column,
  input  logic [scp_pkg::COORD_W-1:0]   line_index,
  input  scp_pkg::bounds_t              bounds,
  output logic [scp_pkg::COUNT_W-1:0]   match_count,
  output logic [scp_pkg::SUM_W-1:0]     column_sum,
  output logic [scp_pkg::SUM_W-1:0]     row_sum
);
  import scp_pkg::*;

  logic             skin;
  logic             in_frame;
  logic [SUM_W:0]   col_wide;
  logic [SUM_W:0]   row_wide;
  logic [SUM_W-1:0] column_sum_next;
  logic [SUM_W-1:0] row_sum_next;

  assign in_frame = (32'(column) < MAX_WIDTH) && (32'(line_index) < MAX_HEIGHT);

  assign skin = (luma > bounds.luma_low) && (luma < bounds.luma_high)
             && (chroma_red > bounds.cr_low) && (chroma_red < bounds.cr_high)
             && (chroma_blue > bounds.cb_low) && (chroma_blue < bounds.cb_high)
             && in_frame;

  assign col_wide = {1'b0, column_sum} + (SUM_W+1)'(column);
  assign row_wide = {1'b0, row_sum} + (SUM_W+1)'(line_index);

  assign column_sum_next = col_wide[SUM_W] ? SUM_MAX : col_wide[SUM_W-1:0];
  assign row_sum_next    = row_wide[SUM_W] ? SUM_MAX : row_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      match_count <= COUNT_W'(1);
      column_sum  <= '0;
      row_sum     <= '0;
    end else if (update && skin && (match_count < COUNT_MAX)) begin
      match_count <= match_count + COUNT_W'(1);
      column_sum  <= column_sum_next;
      row_sum     <= row_sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scp_divider.sv =====
// ----------------------------------------------------------------------------
// Skin pixel centroid shared divider
// Restoring divider, one quotient bit per cycle, used for both coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scp_pkg::SUM_W-1:0]     dividend,
  input  logic [scp_pkg::COUNT_W-1:0]   divisor,
  output scp_pkg::div_stat_t            stat,
  output logic [scp_pkg::COORD_W-1:0]   quotient
);
  import scp_pkg::*;

  // The quotient never exceeds the largest coordinate, so the upper dividend
  // bits are always below the divisor and only the low bits need steps.
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dsr;
  logic [COORD_W-1:0] shift;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W:0]   trial;
  logic               fits;

  assign trial    = {rem, shift[COORD_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      step      <= '0;
    end else if (stat.busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= COUNT_W'(dividend[SUM_W-1:COORD_W]);
      shift <= dividend[COORD_W-1:0];
      dsr   <= divisor;
    end else if (stat.busy) begin
      rem   <= fits ? COUNT_W'(trial - {1'b0, dsr}) : trial[COUNT_W-1:0];
      shift <= {shift[COORD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skin_pixel_centroid.sv =====
// ----------------------------------------------------------------------------
// Skin pixel centroid
// Non-final pixels may be accepted in every cycle. A frame-end pixel blocks
// input while the shared divider runs ten steps for the column and ten for
// the row, and while an earlier result still waits in the output register.
// The centroid is registered once both divisions are done and the output
// register is free. Reset restores the default bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_pixel_centroid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [scp_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [scp_pkg::CHAN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scp_pkg::CHAN_W-1:0]    luma,
  input  logic [scp_pkg::CHAN_W-1:0]    chroma_red,
  input  logic [scp_pkg::CHAN_W-1:0]    chroma_blue,
  input  logic [scp_pkg::COORD_W-1:0]   column,
  input  logic [scp_pkg::COORD_W-1:0]   line_index,
  input  logic                          frame_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scp_pkg::COORD_W-1:0]   center_x,
  output logic [scp_pkg::COORD_W-1:0]   center_y,
  output logic [scp_pkg::COUNT_W-1:0]   skin_pixels
);
  import scp_pkg::*;

`include "skin_pixel_centroid_defines.svh"

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_START_X = 6'b000010,
    ST_DIV_X   = 6'b000100,
    ST_START_Y = 6'b001000,
    ST_DIV_Y   = 6'b010000,
    ST_OUT     = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  bounds_t            bounds;
  logic               in_xfer;
  logic               out_load;
  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  div_stat_t          div_stat;
  logic [COORD_W-1:0] div_quotient;
  logic [COORD_W-1:0] quot_x;
  logic [COUNT_W-1:0] match_count;
  logic [SUM_W-1:0]   column_sum;
  logic [SUM_W-1:0]   row_sum;

  assign in_stall     = (state != ST_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_load     = (state == ST_OUT) && (!out_valid || !out_stall);
  assign div_start    = (state == ST_START_X) || (state == ST_START_Y);
  assign div_dividend = (state == ST_START_Y) ? row_sum : column_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.luma_low  <= RST_LUMA_LOW;
      bounds.luma_high <= RST_LUMA_HIGH;
      bounds.cr_low    <= RST_CR_LOW;
      bounds.cr_high   <= RST_CR_HIGH;
      bounds.cb_low    <= RST_CB_LOW;
      bounds.cb_high   <= RST_CB_HIGH;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_LUMA_LOW:  bounds.luma_low  <= cfg_data;
        REG_LUMA_HIGH: bounds.luma_high <= cfg_data;
        REG_CR_LOW:    bounds.cr_low    <= cfg_data;
        REG_CR_HIGH:   bounds.cr_high   <= cfg_data;
        REG_CB_LOW:    bounds.cb_low    <= cfg_data;
        REG_CB_HIGH:   bounds.cb_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  scp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .clear       (out_load),
    .update      (in_xfer),
    .luma        (luma),
    .chroma_red  (chroma_red),
    .chroma_blue (chroma_blue),
    .column      (column),
    .line_index  (line_index),
    .bounds      (bounds),
    .match_count (match_count),
    .column_sum  (column_sum),
    .row_sum     (row_sum)
  );

  scp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (match_count),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_xfer && frame_end) state_next = ST_START_X;
      ST_START_X: state_next = ST_DIV_X;
      ST_DIV_X:   if (div_stat.done) state_next = ST_START_Y;
      ST_START_Y: state_next = ST_DIV_Y;
      ST_DIV_Y:   if (div_stat.done) state_next = ST_OUT;
      ST_OUT:     if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DIV_X) && div_stat.done) begin
      quot_x <= div_quotient;
    end
    if (out_load) begin
      center_x    <= quot_x;
      center_y    <= div_quotient;
      skin_pixels <= match_count - COUNT_W'(1);
    end
  end

  `SCP_ASSERT_IMPL(a_idle_div_quiet, state == ST_IDLE, !div_stat.busy,
    "Divider is busy while the sequencer is idle.")
  `SCP_ASSERT_NEXT(a_frame_end_starts, in_xfer && frame_end, state == ST_START_X,
    "A frame-end transfer did not start the column division.")
  `SCP_ASSERT_IMPL(a_done_in_div, div_stat.done,
    (state == ST_DIV_X) || (state == ST_DIV_Y),
    "Divider finished outside a division state.")
  `SCP_ASSERT_IMPL(a_count_nonzero, 1'b1, match_count != '0,
    "Match counter reached zero.")

endmodule

`default_nettype wire

// ===== test/skin_pixel_centroid_checker.sv =====
// ----------------------------------------------------------------------------
// Skin pixel centroid checker
// Watches the bound writes and both pixel and result channels, keeps its own
// skin sums per frame and compares each result transfer with the oldest
// predicted centroid.
// ----------------------------------------------------------------------------
module skin_pixel_centroid_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [scp_pkg::INDEX_W-1:0] cfg_index,
  input  logic [scp_pkg::CHAN_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [scp_pkg::CHAN_W-1:0]  luma,
  input  logic [scp_pkg::CHAN_W-1:0]  chroma_red,
  input  logic [scp_pkg::CHAN_W-1:0]  chroma_blue,
  input  logic [scp_pkg::COORD_W-1:0] column,
  input  logic [scp_pkg::COORD_W-1:0] line_index,
  input  logic                        frame_end,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [scp_pkg::COORD_W-1:0] center_x,
  input  logic [scp_pkg::COORD_W-1:0] center_y,
  input  logic [scp_pkg::COUNT_W-1:0] skin_pixels,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COUNT_W-1:0] hits;
  } centroid_t;

  centroid_t          centroid_q[$];
  bounds_t            bounds;
  logic [COUNT_W-1:0] hit_count;
  logic [SUM_W-1:0]   col_acc;
  logic [SUM_W-1:0]   row_acc;

  function automatic bit in_window(logic [CHAN_W-1:0] v, logic [CHAN_W-1:0] lo,
                                   logic [CHAN_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc,
                                               logic [COORD_W-1:0] v);
    logic [SUM_W:0] t;
    t = acc + v;
    return (t > SUM_MAX) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  initial begin
    fail_count = 0;
    pending <= 0;
  end

  always @(posedge clk) begin
    centroid_t got;
    centroid_t want;
    bit        skin;
    if (rst) begin
      bounds = '{RST_LUMA_LOW, RST_LUMA_HIGH, RST_CR_LOW, RST_CR_HIGH,
                 RST_CB_LOW, RST_CB_HIGH};
      hit_count = 1;
      col_acc = '0;
      row_acc = '0;
      centroid_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{center_x, center_y, skin_pixels};
        if (centroid_q.size() == 0) begin
          $error("result: unexpected transfer, center_x %0d center_y %0d skin_pixels %0d",
                 got.cx, got.cy, got.hits);
          fail_count++;
        end else begin
          want = centroid_q.pop_front();
          if (got.cx !== want.cx) begin
            $error("center_x: expected %0d, actual %0d", want.cx, got.cx);
            fail_count++;
          end
          if (got.cy !== want.cy) begin
            $error("center_y: expected %0d, actual %0d", want.cy, got.cy);
            fail_count++;
          end
          if (got.hits !== want.hits) begin
            $error("skin_pixels: expected %0d, actual %0d", want.hits, got.hits);
            fail_count++;
          end
        end
      end

      if (cfg_write_en) begin
        case (cfg_index)
          REG_LUMA_LOW:  bounds.luma_low = cfg_data;
          REG_LUMA_HIGH: bounds.luma_high = cfg_data;
          REG_CR_LOW:    bounds.cr_low = cfg_data;
          REG_CR_HIGH:   bounds.cr_high = cfg_data;
          REG_CB_LOW:    bounds.cb_low = cfg_data;
          REG_CB_HIGH:   bounds.cb_high = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        skin = in_window(luma, bounds.luma_low, bounds.luma_high) &&
               in_window(chroma_red, bounds.cr_low, bounds.cr_high) &&
               in_window(chroma_blue, bounds.cb_low, bounds.cb_high) &&
               (int'(column) < MAX_WIDTH) && (int'(line_index) < MAX_HEIGHT);
        if (skin && hit_count != COUNT_MAX) begin
          hit_count = hit_count + 1'b1;
          col_acc = sat_sum(col_acc, column);
          row_acc = sat_sum(row_acc, line_index);
        end
        if (frame_end) begin
          want.cx = COORD_W'(col_acc / hit_count);
          want.cy = COORD_W'(row_acc / hit_count);
          want.hits = hit_count - 1'b1;
          centroid_q.push_back(want);
          hit_count = 1;
          col_acc = '0;
          row_acc = '0;
        end
      end
    end
    pending <= centroid_q.size();
  end

endmodule

// ===== test/tb_skin_pixel_centroid.sv =====
// ----------------------------------------------------------------------------
// Skin pixel centroid testbench
// Drives directed edge pixels and then random frames under several bound
// settings, with random idle and stall bursts on both channels except in the
// last one; the checker beside the block predicts and compares every centroid.
// ----------------------------------------------------------------------------
module tb_skin_pixel_centroid;
  import scp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write_en;
  logic [INDEX_W-1:0] cfg_index;
  logic [CHAN_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [CHAN_W-1:0]  luma;
  logic [CHAN_W-1:0]  chroma_red;
  logic [CHAN_W-1:0]  chroma_blue;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] line_index;
  logic               frame_end;
  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COUNT_W-1:0] skin_pixels;
  int                 fail_count;
  int                 pending;

  bit                 calm = 1'b0;
  int                 stall_left = 0;
  bounds_t            cur_bounds;

  always #2 clk = ~clk;

  skin_pixel_centroid dut (.*);

  skin_pixel_centroid_checker checker_i (.*);

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CHAN_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_bounds(bounds_t b);
    write_reg(REG_LUMA_LOW, b.luma_low);
    write_reg(REG_LUMA_HIGH, b.luma_high);
    write_reg(REG_CR_LOW, b.cr_low);
    write_reg(REG_CR_HIGH, b.cr_high);
    write_reg(REG_CB_LOW, b.cb_low);
    write_reg(REG_CB_HIGH, b.cb_high);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    cur_bounds = b;
  endtask

  task automatic send_pixel(logic [CHAN_W-1:0] y, logic [CHAN_W-1:0] cr,
                            logic [CHAN_W-1:0] cb, logic [COORD_W-1:0] c,
                            logic [COORD_W-1:0] r, logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    luma <= y;
    chroma_red <= cr;
    chroma_blue <= cb;
    column <= c;
    line_index <= r;
    frame_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted centroid has been transferred, then lets the
  // block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] pick_channel(logic [CHAN_W-1:0] lo,
                                                     logic [CHAN_W-1:0] hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && int'(hi) > int'(lo) + 1)
      return CHAN_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return lo;
        1: return hi;
        2: return lo + 1'b1;
        default: return hi - 1'b1;
      endcase
    end
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_random_frames(int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 16);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        send_pixel(pick_channel(cur_bounds.luma_low, cur_bounds.luma_high),
                   pick_channel(cur_bounds.cr_low, cur_bounds.cr_high),
                   pick_channel(cur_bounds.cb_low, cur_bounds.cb_high),
                   pick_coord(), pick_coord(), i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    bounds_t b;
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    luma <= '0;
    chroma_red <= '0;
    chroma_blue <= '0;
    column <= '0;
    line_index <= '0;
    frame_end <= 1'b0;
    out_stall <= 1'b0;
    cur_bounds = '{RST_LUMA_LOW, RST_LUMA_HIGH, RST_CR_LOW, RST_CR_HIGH,
                   RST_CB_LOW, RST_CB_HIGH};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default bounds: values just inside and just on each exclusive bound.
    send_pixel(8'd100, 8'd150, 8'd128, 10'd0, 10'd0, 1'b0);
    send_pixel(8'd78, 8'd134, 8'd1, 10'd1023, 10'd1023, 1'b0);
    send_pixel(8'd126, 8'd172, 8'd254, 10'd512, 10'd1, 1'b0);
    send_pixel(8'd77, 8'd150, 8'd128, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd127, 8'd150, 8'd128, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd100, 8'd133, 8'd128, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd100, 8'd173, 8'd128, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd100, 8'd150, 8'd0, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd100, 8'd150, 8'd255, 10'd5, 10'd5, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b0);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd1023, 10'd0, 1'b1);
    // A frame with no skin pixel, two back-to-back single pixel frames and a three pixel frame.
    send_pixel(8'd0, 8'd0, 8'd0, 10'd1023, 10'd1023, 1'b1);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd1023, 10'd1023, 1'b1);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd0, 10'd1023, 1'b1);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd1, 10'd5, 1'b0);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd2, 10'd6, 1'b0);
    send_pixel(8'd100, 8'd150, 8'd128, 10'd0, 10'd0, 1'b1);
    drain_results();

    // Fully open bounds, except that 0 and 255 stay outside.
    apply_bounds('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
    send_random_frames(75);
    drain_results();

    // Narrow random windows, with a full pause in the middle.
    for (int k = 0; k < 3; k++) begin
      b.luma_low = CHAN_W'($urandom_range(0, 200));
      b.luma_high = b.luma_low + CHAN_W'($urandom_range(2, 55));
      b.cr_low = CHAN_W'($urandom_range(0, 200));
      b.cr_high = b.cr_low + CHAN_W'($urandom_range(2, 55));
      b.cb_low = CHAN_W'($urandom_range(0, 200));
      b.cb_high = b.cb_low + CHAN_W'($urandom_range(2, 55));
      apply_bounds(b);
      send_random_frames(12);
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
      send_random_frames(13);
      drain_results();
    end

    // Empty windows: inverted and equal bounds, plus writes to unused indexes.
    apply_bounds('{8'd255, 8'd0, 8'd100, 8'd100, 8'd0, 8'd255});
    write_reg(3'd6, CHAN_W'($urandom_range(0, 255)));
    write_reg(3'd7, CHAN_W'($urandom_range(0, 255)));
    cfg_write_en <= 1'b0;
    @(posedge clk);
    send_random_frames(40);
    drain_results();

    // Fully random bounds.
    for (int k = 0; k < 3; k++) begin
      b = bounds_t'(48'({$urandom, $urandom}));
      apply_bounds(b);
      send_random_frames(25);
      drain_results();
    end

    // Back to the defaults with both channels running freely.
    calm = 1'b1;
    apply_bounds('{RST_LUMA_LOW, RST_LUMA_HIGH, RST_CR_LOW, RST_CR_HIGH,
                   RST_CB_LOW, RST_CB_HIGH});
    send_random_frames(117);
    drain_results();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
